// ----- hdl/ata_tf_pkg.sv -----
// Shared types, register codes and field widths for the ATA task-file issue block.
// No dependencies; every other file in hdl/ uses this package.
package ata_tf_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned START_W    = 28;
    localparam int unsigned MASK_W     = 2;
    localparam int unsigned HEADS_W    = 5;
    localparam int unsigned SECT_W     = 6;
    localparam int unsigned PCYL_W     = HEADS_W + SECT_W;
    localparam int unsigned CYL_W      = 16;
    localparam int unsigned HEAD_W     = 4;
    localparam int unsigned OFS_W      = 3;
    localparam int unsigned OC_W       = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 6;

    // One divider cell per quotient bit
    localparam int unsigned CYL_CELLS  = START_W;
    localparam int unsigned HEAD_CELLS = PCYL_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LBA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS1 = 3'd5;

    localparam logic [HEADS_W-1:0] HEADS_RST   = 5'd16;
    localparam logic [SECT_W-1:0]  SECTORS_RST = 6'd63;

    // Task-file register offsets
    localparam logic [OFS_W-1:0] OFS_NONE    = 3'd0;
    localparam logic [OFS_W-1:0] OFS_COUNT   = 3'd2;
    localparam logic [OFS_W-1:0] OFS_SECTOR  = 3'd3;
    localparam logic [OFS_W-1:0] OFS_CYL_LO  = 3'd4;
    localparam logic [OFS_W-1:0] OFS_CYL_HI  = 3'd5;
    localparam logic [OFS_W-1:0] OFS_DEVHEAD = 3'd6;
    localparam logic [OFS_W-1:0] OFS_CMD     = 3'd7;

    localparam logic [BYTE_W-1:0] DEV_BASE    = 8'hA0;
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'h30;
    localparam logic [BYTE_W-1:0] STATUS_HOLD = 8'h88;

    typedef enum logic [OC_W-1:0] {
        OC_OK     = 2'd0,
        OC_ABSENT = 2'd1,
        OC_BUSY   = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        STEP_SEL     = 3'd0,
        STEP_COUNT   = 3'd1,
        STEP_SECTOR  = 3'd2,
        STEP_CYL_LO  = 3'd3,
        STEP_CYL_HI  = 3'd4,
        STEP_DEVHEAD = 3'd5,
        STEP_CMD     = 3'd6
    } t_step;

    // Request data that travels alongside the divider chain
    typedef struct packed {
        logic                cmd;
        logic                drv;
        t_outcome            outcome;
        logic                lba;
        logic [BYTE_W-1:0]   count;
        logic [START_W-1:0]  start;
        logic [SECT_W-1:0]   sect;
        logic [CYL_W-1:0]    cyl;
    } t_side;

    // Finished request, ready to be written out
    typedef struct packed {
        logic                cmd;
        logic                drv;
        t_outcome            outcome;
        logic                lba;
        logic [BYTE_W-1:0]   count;
        logic [BYTE_W-1:0]   sector;
        logic [BYTE_W-1:0]   cyl_lo;
        logic [BYTE_W-1:0]   cyl_hi;
        logic [HEAD_W-1:0]   head;
    } t_item;

endpackage

// ----- hdl/ata_tf_req_if.sv -----
// Request channel: valid/ready handshake with one block request as payload.
// Depends on ata_tf_pkg for field widths.
interface ata_tf_req_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic                               drive;
    logic [ata_tf_pkg::START_W-1:0]     start_block;
    logic [ata_tf_pkg::BYTE_W-1:0]      sector_count;
    logic [ata_tf_pkg::BYTE_W-1:0]      device_status;

    modport source (
        output valid, cmd, drive, start_block, sector_count, device_status,
        input  ready
    );
    modport sink (
        input  valid, cmd, drive, start_block, sector_count, device_status,
        output ready
    );
endinterface

// ----- hdl/ata_tf_res_if.sv -----
// Result channel: valid/ready handshake with one task-file write or error as payload.
// Depends on ata_tf_pkg for field widths.
interface ata_tf_res_if;
    logic                               valid;
    logic                               ready;
    logic [ata_tf_pkg::OFS_W-1:0]       reg_offset;
    logic [ata_tf_pkg::BYTE_W-1:0]      reg_value;
    logic                               write_valid;
    logic [ata_tf_pkg::OC_W-1:0]        outcome;
    logic                               last;

    modport source (
        output valid, reg_offset, reg_value, write_valid, outcome, last,
        input  ready
    );
    modport sink (
        input  valid, reg_offset, reg_value, write_valid, outcome, last,
        output ready
    );
endinterface

// ----- hdl/ata_taskfile_command_issue_core.sv -----
// Request path: one setup stage, 28 cylinder divider cells, 11 head/sector divider
// cells, output sequencer. The output sequencer issues one task-file write per cycle
// while the result side is ready, and takes the next finished request only with the
// last result of the one it holds. The divider chain takes a new request each cycle
// until a finished request waits at its end. Synchronous reset empties the chain and
// sets 16 heads, 63 sectors, no drives present, CHS addressing.
module ata_taskfile_command_issue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ata_tf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ata_tf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    ata_tf_req_if.sink                          i_req,
    ata_tf_res_if.source                        o_res
);
    import ata_tf_pkg::*;

    // Configuration registers
    logic [MASK_W-1:0]  r_present;
    logic [MASK_W-1:0]  r_lba;
    logic [HEADS_W-1:0] r_heads0;
    logic [SECT_W-1:0]  r_sectors0;
    logic [HEADS_W-1:0] r_heads1;
    logic [SECT_W-1:0]  r_sectors1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_lba      <= '0;
            r_heads0   <= HEADS_RST;
            r_sectors0 <= SECTORS_RST;
            r_heads1   <= HEADS_RST;
            r_sectors1 <= SECTORS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESENT:  r_present  <= i_cfg_wdata[MASK_W-1:0];
                CFG_LBA:      r_lba      <= i_cfg_wdata[MASK_W-1:0];
                CFG_HEADS0:   r_heads0   <= i_cfg_wdata[HEADS_W-1:0];
                CFG_SECTORS0: r_sectors0 <= i_cfg_wdata[SECT_W-1:0];
                CFG_HEADS1:   r_heads1   <= i_cfg_wdata[HEADS_W-1:0];
                CFG_SECTORS1: r_sectors1 <= i_cfg_wdata[SECT_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic w_take;

    // Setup stage: classify the request and form heads*sectors
    logic [HEADS_W-1:0] w_heads;
    logic [SECT_W-1:0]  w_sects;
    logic [PCYL_W-1:0]  w_pcyl;
    t_side              w_side_in;

    always_comb begin
        w_heads = i_req.drive ? r_heads1 : r_heads0;
        w_sects = i_req.drive ? r_sectors1 : r_sectors0;
        // zero geometry counts as one
        if (w_heads == '0) w_heads = HEADS_W'(1);
        if (w_sects == '0) w_sects = SECT_W'(1);
        w_pcyl = PCYL_W'(w_heads) * PCYL_W'(w_sects);

        w_side_in.cmd   = i_req.cmd;
        w_side_in.drv   = i_req.drive;
        w_side_in.lba   = r_lba[i_req.drive];
        w_side_in.count = i_req.sector_count;
        w_side_in.start = i_req.start_block;
        w_side_in.sect  = w_sects;
        w_side_in.cyl   = '0;
        priority if (!r_present[i_req.drive]) begin
            w_side_in.outcome = OC_ABSENT;
        end else if ((i_req.device_status & STATUS_HOLD) != '0) begin
            w_side_in.outcome = OC_BUSY;
        end else begin
            w_side_in.outcome = OC_OK;
        end
    end

    logic               r_f_valid;
    logic [START_W-1:0] r_f_word;
    logic [PCYL_W-1:0]  r_f_div;
    t_side              r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_adv) begin
            r_f_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_word <= i_req.start_block;
            r_f_div  <= w_pcyl;
            r_f_side <= w_side_in;
        end
    end

    assign i_req.ready = w_adv;

    // Cylinder chain: start_block / (heads*sectors)
    logic               c1_v    [0:CYL_CELLS];
    logic [START_W-1:0] c1_w    [0:CYL_CELLS];
    logic [PCYL_W-1:0]  c1_r    [0:CYL_CELLS];
    logic [PCYL_W-1:0]  c1_d    [0:CYL_CELLS];
    t_side              c1_s    [0:CYL_CELLS];

    assign c1_v[0] = r_f_valid;
    assign c1_w[0] = r_f_word;
    assign c1_r[0] = '0;
    assign c1_d[0] = r_f_div;
    assign c1_s[0] = r_f_side;

    for (genvar k = 0; k < CYL_CELLS; k++) begin : g_cyl
        ata_tf_div_cell #(
            .W  (START_W),
            .RW (PCYL_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c1_v[k]),
            .i_word  (c1_w[k]),
            .i_rem   (c1_r[k]),
            .i_div   (c1_d[k]),
            .i_side  (c1_s[k]),
            .o_valid (c1_v[k+1]),
            .o_word  (c1_w[k+1]),
            .o_rem   (c1_r[k+1]),
            .o_div   (c1_d[k+1]),
            .o_side  (c1_s[k+1])
        );
    end

    // Head chain: cylinder remainder / sectors
    logic               c2_v    [0:HEAD_CELLS];
    logic [PCYL_W-1:0]  c2_w    [0:HEAD_CELLS];
    logic [SECT_W-1:0]  c2_r    [0:HEAD_CELLS];
    logic [SECT_W-1:0]  c2_d    [0:HEAD_CELLS];
    t_side              c2_s    [0:HEAD_CELLS];

    always_comb begin
        c2_s[0]     = c1_s[CYL_CELLS];
        c2_s[0].cyl = c1_w[CYL_CELLS][CYL_W-1:0];
    end

    assign c2_v[0] = c1_v[CYL_CELLS];
    assign c2_w[0] = c1_r[CYL_CELLS];
    assign c2_r[0] = '0;
    assign c2_d[0] = c1_s[CYL_CELLS].sect;

    for (genvar k = 0; k < HEAD_CELLS; k++) begin : g_head
        ata_tf_div_cell #(
            .W  (PCYL_W),
            .RW (SECT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c2_v[k]),
            .i_word  (c2_w[k]),
            .i_rem   (c2_r[k]),
            .i_div   (c2_d[k]),
            .i_side  (c2_s[k]),
            .o_valid (c2_v[k+1]),
            .o_word  (c2_w[k+1]),
            .o_rem   (c2_r[k+1]),
            .o_div   (c2_d[k+1]),
            .o_side  (c2_s[k+1])
        );
    end

    // Pick LBA bytes or CHS fields for the finished request
    t_side w_end;
    t_item w_item;

    always_comb begin
        w_end          = c2_s[HEAD_CELLS];
        w_item.cmd     = w_end.cmd;
        w_item.drv     = w_end.drv;
        w_item.outcome = w_end.outcome;
        w_item.lba     = w_end.lba;
        w_item.count   = w_end.count;
        if (w_end.lba) begin
            w_item.sector = w_end.start[7:0];
            w_item.cyl_lo = w_end.start[15:8];
            w_item.cyl_hi = w_end.start[23:16];
            w_item.head   = w_end.start[START_W-1:24];
        end else begin
            w_item.sector = {{(BYTE_W-SECT_W){1'b0}}, c2_r[HEAD_CELLS]} + BYTE_W'(1);
            w_item.cyl_lo = w_end.cyl[7:0];
            w_item.cyl_hi = w_end.cyl[15:8];
            w_item.head   = c2_w[HEAD_CELLS][HEAD_W-1:0];
        end
    end

    // Advance the whole chain unless the last cell holds a request the sequencer cannot take
    assign w_adv = !c2_v[HEAD_CELLS] || w_take;

    ata_tf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c2_v[HEAD_CELLS]),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_res   (o_res)
    );

    a_err_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.outcome != OC_OK) |-> !o_res.write_valid && o_res.last)
        else $error("error result carries a write or is not last");

    a_take_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_res.valid)
        else $error("request handed to sequencer but no result shown");

    a_end_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c2_v[HEAD_CELLS] && !w_take |=> c2_v[HEAD_CELLS] && $stable(w_item))
        else $error("finished request dropped or changed while stalled");

    a_stall_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> !i_req.ready && c2_v[HEAD_CELLS])
        else $error("chain stalled without a waiting request");

endmodule

// ----- hdl/ata_tf_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per stage and passes the
// partial remainder, divisor and request data to the next cell. Uses ata_tf_pkg.
module ata_tf_div_cell #(
    parameter int unsigned W  = ata_tf_pkg::START_W,
    parameter int unsigned RW = ata_tf_pkg::PCYL_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [W-1:0]        i_word,
    input  logic [RW-1:0]       i_rem,
    input  logic [RW-1:0]       i_div,
    input  ata_tf_pkg::t_side   i_side,
    output logic                o_valid,
    output logic [W-1:0]        o_word,
    output logic [RW-1:0]       o_rem,
    output logic [RW-1:0]       o_div,
    output ata_tf_pkg::t_side   o_side
);
    import ata_tf_pkg::*;

    logic           r_valid;
    logic [W-1:0]   r_word;
    logic [RW-1:0]  r_rem;
    logic [RW-1:0]  r_div;
    t_side          r_side;

    logic [RW:0]    w_trial;
    logic [RW:0]    w_diff;
    logic           w_ge;

    // Bring down the next dividend bit; the word shifts quotient bits in from the right
    assign w_trial = {i_rem, i_word[W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_div});
    assign w_diff  = w_trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= {i_word[W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

// ----- hdl/ata_tf_emit.sv -----
// Output sequencer: holds one finished request and emits its task-file writes, one transfer
// per cycle while o_res.ready is high, or its single error result. Uses ata_tf_pkg, ata_tf_res_if.
module ata_tf_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ata_tf_pkg::t_item   i_item,
    output logic                o_take,
    ata_tf_res_if.source        o_res
);
    import ata_tf_pkg::*;

    logic   r_valid, n_valid;
    t_step  r_step, n_step;
    t_step  w_step_inc;
    t_item  r_item;
    logic   w_xfer;
    logic   w_last;

    assign w_xfer = r_valid && o_res.ready;
    assign o_take = i_valid && (!r_valid || (w_xfer && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_SEL;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (o_take) begin
            n_valid = 1'b1;
            n_step  = STEP_SEL;
        end else if (w_xfer) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_step = w_step_inc;
            end
        end
    end

    always_comb begin
        o_res.valid       = r_valid;
        o_res.reg_offset  = OFS_NONE;
        o_res.reg_value   = '0;
        o_res.write_valid = 1'b0;
        o_res.outcome     = r_item.outcome;
        o_res.last        = 1'b1;
        w_step_inc        = STEP_SEL;
        w_last            = 1'b1;
        if (r_item.outcome == OC_OK) begin
            o_res.write_valid = 1'b1;
            o_res.last        = 1'b0;
            w_last            = 1'b0;
            unique case (r_step)
                STEP_SEL: begin
                    o_res.reg_offset = OFS_DEVHEAD;
                    o_res.reg_value  = DEV_BASE | {3'b000, r_item.drv, 4'b0000};
                    w_step_inc       = STEP_COUNT;
                end
                STEP_COUNT: begin
                    o_res.reg_offset = OFS_COUNT;
                    o_res.reg_value  = r_item.count;
                    w_step_inc       = STEP_SECTOR;
                end
                STEP_SECTOR: begin
                    o_res.reg_offset = OFS_SECTOR;
                    o_res.reg_value  = r_item.sector;
                    w_step_inc       = STEP_CYL_LO;
                end
                STEP_CYL_LO: begin
                    o_res.reg_offset = OFS_CYL_LO;
                    o_res.reg_value  = r_item.cyl_lo;
                    w_step_inc       = STEP_CYL_HI;
                end
                STEP_CYL_HI: begin
                    o_res.reg_offset = OFS_CYL_HI;
                    o_res.reg_value  = r_item.cyl_hi;
                    w_step_inc       = STEP_DEVHEAD;
                end
                STEP_DEVHEAD: begin
                    o_res.reg_offset = OFS_DEVHEAD;
                    o_res.reg_value  = DEV_BASE
                                     | {1'b0, r_item.lba, 1'b0, r_item.drv, r_item.head};
                    w_step_inc       = STEP_CMD;
                end
                STEP_CMD: begin
                    o_res.reg_offset = OFS_CMD;
                    o_res.reg_value  = r_item.cmd ? CMD_WRITE : CMD_READ;
                    o_res.last       = 1'b1;
                    w_last           = 1'b1;
                end
                default: begin
                    o_res.write_valid = 1'b0;
                    o_res.last        = 1'b1;
                    w_last            = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- tb/ata_taskfile_command_issue_core_tb.sv -----
// Testbench for ata_taskfile_command_issue_core: directed and random block requests,
// with each task-file write and error result checked against a built-in predictor.
// Depends on ata_tf_pkg and the ata_tf_req_if / ata_tf_res_if interfaces.
module ata_taskfile_command_issue_core_tb;
    import ata_tf_pkg::*;

    typedef struct packed {
        logic [OFS_W-1:0]  offset;
        logic [BYTE_W-1:0] value;
        logic              is_write;
        t_outcome          outcome;
        logic              last;
    } t_tf_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    ata_tf_req_if req_if ();
    ata_tf_res_if res_if ();

    ata_taskfile_command_issue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Shadow copy of the block's registers
    logic [MASK_W-1:0]  present_m = '0;
    logic [MASK_W-1:0]  lba_m     = '0;
    logic [HEADS_W-1:0] heads_d [2] = '{HEADS_RST, HEADS_RST};
    logic [SECT_W-1:0]  sectors_d [2] = '{SECTORS_RST, SECTORS_RST};

    t_tf_result  expected_q [$];
    int unsigned n_fail     = 0;
    int unsigned n_requests = 0;
    int unsigned n_writes   = 0;
    int unsigned n_rejects  = 0;
    int unsigned n_settings = 0;
    bit          src_idle   = 1'b1;
    bit          sink_idle  = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("ata_taskfile_command_issue_core_tb failed");
        $finish;
    end

    function automatic void expect_result(logic [OFS_W-1:0] ofs, logic [BYTE_W-1:0] val,
                                          logic wv, t_outcome oc, logic last);
        expected_q.push_back(t_tf_result'{ofs, val, wv, oc, last});
    endfunction

    // Build the task-file write sequence for one request
    function automatic void predict_taskfile(logic cmd, logic drv, logic [START_W-1:0] start,
                                             logic [BYTE_W-1:0] count,
                                             logic [BYTE_W-1:0] status);
        int unsigned h, s, per_cyl, cyl, rem;
        logic              uses_lba;
        logic [BYTE_W-1:0] sec, cyl_lo, cyl_hi;
        logic [HEAD_W-1:0] head;
        if (!present_m[drv]) begin
            expect_result(OFS_NONE, 8'h00, 1'b0, OC_ABSENT, 1'b1);
            return;
        end
        if ((status & STATUS_HOLD) != 0) begin
            expect_result(OFS_NONE, 8'h00, 1'b0, OC_BUSY, 1'b1);
            return;
        end
        uses_lba = lba_m[drv];
        if (uses_lba) begin
            sec    = start[7:0];
            cyl_lo = start[15:8];
            cyl_hi = start[23:16];
            head   = start[27:24];
        end else begin
            // zero geometry counts as one
            h = (heads_d[drv] == 0) ? 1 : 32'(heads_d[drv]);
            s = (sectors_d[drv] == 0) ? 1 : 32'(sectors_d[drv]);
            per_cyl = h * s;
            cyl     = (int'(start) / per_cyl) & 32'hFFFF;
            rem     = int'(start) % per_cyl;
            sec     = BYTE_W'(rem % s + 1);
            cyl_lo  = cyl[7:0];
            cyl_hi  = cyl[15:8];
            head    = HEAD_W'(rem / s);
        end
        expect_result(OFS_DEVHEAD, DEV_BASE | {3'b000, drv, 4'h0}, 1'b1, OC_OK, 1'b0);
        expect_result(OFS_COUNT, count, 1'b1, OC_OK, 1'b0);
        expect_result(OFS_SECTOR, sec, 1'b1, OC_OK, 1'b0);
        expect_result(OFS_CYL_LO, cyl_lo, 1'b1, OC_OK, 1'b0);
        expect_result(OFS_CYL_HI, cyl_hi, 1'b1, OC_OK, 1'b0);
        expect_result(OFS_DEVHEAD, DEV_BASE | {1'b0, uses_lba, 1'b0, drv, head},
                      1'b1, OC_OK, 1'b0);
        expect_result(OFS_CMD, cmd ? CMD_WRITE : CMD_READ, 1'b1, OC_OK, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin : check_result
            t_tf_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: offset %0d value %0h outcome %0d",
                       res_if.reg_offset, res_if.reg_value, res_if.outcome);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                check_field("reg_offset", 8'(want.offset), 8'(res_if.reg_offset));
                check_field("reg_value", want.value, res_if.reg_value);
                check_field("write_valid", 8'(want.is_write), 8'(res_if.write_valid));
                check_field("outcome", 8'(want.outcome), 8'(res_if.outcome));
                check_field("last", 8'(want.last), 8'(res_if.last));
            end
            if (res_if.write_valid) n_writes++;
            else                    n_rejects++;
        end
    end

    // Result side: when sink_idle is set, hold ready low for a random stall before each transfer
    always begin : res_pacer
        int unsigned stall;
        stall = sink_idle ? $urandom_range(0, 11) : 0;
        if (stall > 0) begin
            res_if.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        res_if.ready <= 1'b1;
        do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
    end

    // Valid stays high after a transfer; only drop it when a gap follows
    task automatic send_request(input logic cmd, input logic drv,
                                input logic [START_W-1:0] start,
                                input logic [BYTE_W-1:0] count,
                                input logic [BYTE_W-1:0] status);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.cmd           <= cmd;
        req_if.drive         <= drv;
        req_if.start_block   <= start;
        req_if.sector_count  <= count;
        req_if.device_status <= status;
        req_if.valid         <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        predict_taskfile(cmd, drv, start, count, status);
        n_requests++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Hold the write enable across back-to-back writes; drop it after the final one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit more);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (!more) i_cfg_we <= 1'b0;
        case (idx)
            CFG_PRESENT:  present_m    = data[MASK_W-1:0];
            CFG_LBA:      lba_m        = data[MASK_W-1:0];
            CFG_HEADS0:   heads_d[0]   = data[HEADS_W-1:0];
            CFG_SECTORS0: sectors_d[0] = data[SECT_W-1:0];
            CFG_HEADS1:   heads_d[1]   = data[HEADS_W-1:0];
            CFG_SECTORS1: sectors_d[1] = data[SECT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] pres, input logic [1:0] lba,
                             input logic [4:0] h0, input logic [5:0] s0,
                             input logic [4:0] h1, input logic [5:0] s1);
        cfg_write(CFG_PRESENT, CFG_DATA_W'(pres), 1'b1);
        cfg_write(CFG_LBA, CFG_DATA_W'(lba), 1'b1);
        cfg_write(CFG_HEADS0, CFG_DATA_W'(h0), 1'b1);
        cfg_write(CFG_SECTORS0, s0, 1'b1);
        cfg_write(CFG_HEADS1, CFG_DATA_W'(h1), 1'b1);
        cfg_write(CFG_SECTORS1, s1, 1'b0);
        n_settings++;
    endtask

    // No drive present out of reset; then default 16/63 CHS geometry
    task automatic test_reset_defaults();
        send_request(1'b0, 1'b0, 28'h0000010, 8'h01, 8'h00);
        send_request(1'b1, 1'b1, 28'h0000010, 8'h01, 8'h00);
        drain_results();
        cfg_write(CFG_PRESENT, 6'd3, 1'b0);
        send_request(1'b0, 1'b0, 28'd0, 8'h01, 8'h00);
        send_request(1'b1, 1'b1, 28'd1007, 8'h10, 8'h40);
        send_request(1'b0, 1'b0, 28'd1008, 8'h20, 8'h50);
        drain_results();
    endtask

    task automatic test_lba_addressing();
        configure(2'b11, 2'b11, 5'd16, 6'd63, 5'd16, 6'd63);
        send_request(1'b0, 1'b0, 28'h0000000, 8'h00, 8'h00);
        send_request(1'b1, 1'b1, 28'hFFFFFFF, 8'hFF, 8'h77);
        send_request(1'b1, 1'b0, 28'hA5C3E1F, 8'h80, 8'h50);
        drain_results();
    endtask

    // BSY and DRQ reject a request; an absent drive wins over a busy status
    task automatic test_status_checks();
        configure(2'b01, 2'b01, 5'd1, 6'd1, 5'd16, 6'd63);
        send_request(1'b0, 1'b0, 28'h1234567, 8'h08, 8'h80);
        send_request(1'b1, 1'b0, 28'h1234567, 8'h08, 8'h08);
        send_request(1'b0, 1'b0, 28'h1234567, 8'h08, 8'hFF);
        send_request(1'b1, 1'b1, 28'h1234567, 8'h08, 8'h88);
        send_request(1'b1, 1'b0, 28'h1234567, 8'h08, 8'h00);
        drain_results();
    endtask

    // Zero geometry, head wraparound above 16 heads, cylinder truncation
    task automatic test_chs_corners();
        configure(2'b11, 2'b00, 5'd0, 6'd0, 5'd31, 6'd1);
        send_request(1'b0, 1'b0, 28'hFFFFFFF, 8'h01, 8'h00);
        send_request(1'b1, 1'b1, 28'd30, 8'h02, 8'h00);
        send_request(1'b0, 1'b1, 28'd31 * 28'd70000 + 28'd17, 8'h03, 8'h00);
        drain_results();
        configure(2'b11, 2'b10, 5'd1, 6'd63, 5'd16, 6'd1);
        send_request(1'b0, 1'b0, 28'hFFFFFFF, 8'hFF, 8'h00);
        send_request(1'b1, 1'b1, 28'h0F0F0F0, 8'h7F, 8'h00);
        drain_results();
    endtask

    function automatic int unsigned pick_dim(int unsigned usual_top, int unsigned reg_top);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, reg_top)
                                           : $urandom_range(1, usual_top);
    endfunction

    task automatic test_random_traffic();
        logic [1:0]         pres;
        logic               drv;
        logic [START_W-1:0] start;
        logic [BYTE_W-1:0]  status;
        for (int phase = 0; phase < 6; phase++) begin
            pres = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
            configure(pres, 2'($urandom_range(0, 3)),
                      5'(pick_dim(16, 31)), 6'(pick_dim(63, 63)),
                      5'(pick_dim(16, 31)), 6'(pick_dim(63, 63)));
            src_idle  = (phase == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            sink_idle = (phase == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            for (int i = 0; i < 33; i++) begin
                drv = 1'($urandom_range(0, 1));
                // steer most requests to a present drive
                if (!present_m[drv] && present_m != 0 && $urandom_range(0, 9) != 0)
                    drv = ~drv;
                start = ($urandom_range(0, 1) == 0) ? START_W'($urandom)
                                                    : START_W'($urandom_range(0, 70000));
                status = 8'($urandom);
                if ($urandom_range(0, 5) != 0) status = status & ~STATUS_HOLD;
                send_request(1'($urandom_range(0, 1)), drv, start, 8'($urandom), status);
                if (phase == 2 && i == 18) drain_results();
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_PRESENT;
        i_cfg_wdata          = '0;
        req_if.valid         = 1'b0;
        req_if.cmd           = 1'b0;
        req_if.drive         = 1'b0;
        req_if.start_block   = '0;
        req_if.sector_count  = '0;
        req_if.device_status = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_lba_addressing();
        test_status_checks();
        test_chs_corners();
        test_random_traffic();

        repeat (60) @(posedge i_clk);
        $display("Covered %0d requests over %0d register settings:", n_requests, n_settings);
        $display("  %0d task-file writes and %0d rejected requests checked",
                 n_writes, n_rejects);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("ata_taskfile_command_issue_core_tb passed");
        end else begin
            $display("ata_taskfile_command_issue_core_tb failed");
        end
        $finish;
    end

endmodule
